// ----- hdl/sfa_pkg.sv -----
package sfa_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 28;
    localparam int INT_W      = POS_W - FRAC_BITS;
    localparam int FR_W       = INT_W + 2;
    localparam int FRM_W      = 10;
    localparam int CMP_W      = (FR_W > FRM_W + 1) ? FR_W : FRM_W + 1;
    localparam int RATE_W     = 10;
    localparam int DT_W       = 16;
    localparam int PROD_W     = RATE_W + DT_W;
    localparam int GUARD_W    = 8;
    localparam int STEP_SHR   = 24 - FRAC_BITS;
    localparam int STEP_W     = PROD_W + FRAC_BITS - 16;
    localparam int SUM_W      = ((STEP_W > POS_W) ? STEP_W : POS_W) + 2;
    localparam int FTP_W      = ((FRM_W + FRAC_BITS > POS_W) ? FRM_W + FRAC_BITS : POS_W) + 1;
    localparam int IDX_W      = 9;
    localparam int CNT_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]        CNT_MAX = {CNT_W{1'b1}};

    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_REVERSED = 2'd1,
        MODE_PINGPONG = 2'd2
    } t_anim_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_FRAME  = 3'd0,
        CFG_FRAME_COUNT  = 3'd1,
        CFG_ANIM_MODE    = 3'd2,
        CFG_REPEAT_LIMIT = 3'd3,
        CFG_FRAME_RATE   = 3'd4
    } t_cfg_addr;

    typedef struct packed {
        logic [7:0]        start_frame;
        logic [8:0]        frame_count;
        logic [1:0]        anim_mode;
        logic [CNT_W-1:0]  repeat_limit;
        logic [RATE_W-1:0] frame_rate;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] frame_index;
        logic             running;
        logic             end_reached;
    } t_result;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-POS_W){1'b0}}, POS_MAX};
        lo = {{(SUM_W-POS_W){1'b1}}, POS_MIN};
        if (v > hi) begin
            return POS_MAX;
        end else if (v < lo) begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] frame_to_pos(input logic [FRM_W-1:0] f);
        logic [FTP_W-1:0] w;
        logic [FTP_W-1:0] lim;
        w   = {{(FTP_W-FRM_W-FRAC_BITS){1'b0}}, f, {FRAC_BITS{1'b0}}};
        lim = {{(FTP_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
        if (w > lim) begin
            return POS_MAX;
        end
        return w[POS_W-1:0];
    endfunction

    // integer part, truncated toward zero
    function automatic logic signed [FR_W-1:0] pos_to_frame(input logic signed [POS_W-1:0] p);
        logic [POS_W:0]  ext;
        logic [POS_W:0]  mag;
        logic [FR_W-1:0] q;
        ext = {p[POS_W-1], p};
        mag = ext[POS_W] ? (~ext + 1'b1) : ext;
        q   = FR_W'(mag >> FRAC_BITS);
        return ext[POS_W] ? $signed(~q + 1'b1) : $signed(q);
    endfunction

endpackage

// ----- hdl/sfa_step.sv -----
module sfa_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sfa_pkg::DT_W-1:0]   s_axis_tdata,
    input  logic                       s_axis_tuser,
    input  logic [sfa_pkg::RATE_W-1:0] i_frame_rate,
    input  logic                       i_next_ready,
    output logic                       o_valid,
    output logic                       o_action,
    output logic [sfa_pkg::STEP_W-1:0] o_step
);
    import sfa_pkg::*;

    logic                       r_valid;
    logic                       r_action;
    logic [STEP_W-1:0]          r_step;
    logic [PROD_W-1:0]          n_prod;
    logic [PROD_W+GUARD_W-1:0]  n_scaled;

    assign n_prod   = i_frame_rate * s_axis_tdata;
    assign n_scaled = {n_prod, {GUARD_W{1'b0}}} >> STEP_SHR;

    assign s_axis_tready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tuser;
            r_step   <= n_scaled[STEP_W-1:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_step   = r_step;

endmodule

// ----- hdl/sfa_core.sv -----
module sfa_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sfa_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    input  logic                       i_action,
    input  logic [sfa_pkg::STEP_W-1:0] i_step,
    output logic                       o_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output sfa_pkg::t_result           o_result
);
    import sfa_pkg::*;

    logic signed [POS_W-1:0] r_pos;
    logic                    r_back;
    logic                    r_run;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    t_result                 r_result;

    logic signed [POS_W-1:0] n_pos;
    logic                    n_back;
    logic                    n_run;
    logic [CNT_W-1:0]        n_cnt;
    logic                    n_hit;
    t_result                 n_result;

    logic [FRM_W-1:0]        w_first;
    logic [FRM_W-1:0]        w_last;
    logic [8:0]              w_count;
    logic signed [SUM_W-1:0] w_pos_ext;
    logic signed [SUM_W-1:0] w_step_ext;
    logic signed [POS_W-1:0] w_moved;
    logic signed [FR_W-1:0]  w_fr;
    logic signed [CMP_W-1:0] w_fr_c;
    logic signed [CMP_W-1:0] w_first_c;
    logic signed [CMP_W-1:0] w_last_c;
    logic                    w_past_last;
    logic                    w_below_first;
    logic [FRM_W-1:0]        w_freeze;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic                    w_accept;
    logic signed [FR_W-1:0]  w_out_fr;

    assign w_count = (i_cfg.frame_count == '0) ? 9'd1 : i_cfg.frame_count;
    assign w_first = {2'b00, i_cfg.start_frame};
    assign w_last  = w_first + {1'b0, w_count} - 1'b1;

    assign w_pos_ext  = {{(SUM_W-POS_W){r_pos[POS_W-1]}}, r_pos};
    assign w_step_ext = {{(SUM_W-STEP_W){1'b0}}, i_step};
    assign w_cnt_inc  = (r_cnt < CNT_MAX) ? r_cnt + 1'b1 : r_cnt;

    assign w_first_c = $signed({{(CMP_W-FRM_W){1'b0}}, w_first});
    assign w_last_c  = $signed({{(CMP_W-FRM_W){1'b0}}, w_last});

    always_comb begin
        n_pos         = r_pos;
        n_back        = r_back;
        n_run         = r_run;
        n_cnt         = r_cnt;
        n_hit         = 1'b0;
        w_freeze      = '0;
        w_moved       = r_pos;
        w_fr          = '0;
        w_fr_c        = '0;
        w_past_last   = 1'b0;
        w_below_first = 1'b0;
        if (i_action == ACT_RESTART) begin
            n_pos  = frame_to_pos(w_first);
            n_back = 1'b0;
            n_run  = 1'b1;
            n_cnt  = '0;
        end else if (r_run) begin
            if (i_cfg.anim_mode == MODE_REVERSED) begin
                n_back = 1'b1;
            end
            w_moved       = sat_pos(n_back ? w_pos_ext - w_step_ext : w_pos_ext + w_step_ext);
            n_pos         = w_moved;
            w_fr          = pos_to_frame(w_moved);
            w_fr_c        = CMP_W'(w_fr);
            w_past_last   = w_fr_c > w_last_c;
            w_below_first = w_fr_c < w_first_c;
            unique case (i_cfg.anim_mode)
                MODE_NORMAL: begin
                    if (w_past_last) begin
                        n_pos    = frame_to_pos(w_first);
                        w_freeze = w_last;
                        n_hit    = 1'b1;
                    end
                end
                MODE_REVERSED: begin
                    if (w_below_first) begin
                        n_pos    = frame_to_pos(w_last);
                        w_freeze = w_first;
                        n_hit    = 1'b1;
                    end
                end
                MODE_PINGPONG: begin
                    if (!n_back && w_past_last) begin
                        n_pos    = frame_to_pos(w_last);
                        n_back   = 1'b1;
                        w_freeze = w_last;
                        n_hit    = 1'b1;
                    end else if (n_back && w_below_first) begin
                        n_pos    = frame_to_pos(w_first);
                        n_back   = 1'b0;
                        w_freeze = w_first;
                        n_hit    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (n_hit && i_cfg.repeat_limit != '0) begin
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= i_cfg.repeat_limit) begin
                    n_pos = frame_to_pos(w_freeze);
                    n_run = 1'b0;
                end
            end
        end
    end

    assign w_out_fr             = pos_to_frame(n_pos);
    assign n_result.frame_index = w_out_fr[IDX_W-1:0];
    assign n_result.running     = n_run;
    assign n_result.end_reached = n_hit;

    assign o_ready  = !r_out_valid || i_out_ready;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_back      <= 1'b0;
            r_run       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_pos       <= n_pos;
            r_back      <= n_back;
            r_run       <= n_run;
            r_cnt       <= n_cnt;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// ----- hdl/sprite_frame_animator.sv -----
// a result passes through the input stage register and then the core's result register
// throughput: one transaction per cycle while the output is not stalled, set by the position update loop
// the rate x elapsed-time product is registered in the input stage
// reset: synchronous, active low; clears position, direction, running flag,
// repeat counter, pipeline valids and the config registers to their defaults
module sprite_frame_animator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // delta_time
    input  logic                           s_axis_tuser,  // action
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // frame_index, zero pad
    output logic                           m_axis_tuser,  // running
    output logic                           m_axis_tlast,  // end_reached
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfa_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfa_pkg::*;

    t_cfg              r_cfg;
    logic              w_s1_valid;
    logic              w_s1_action;
    logic [STEP_W-1:0] w_s1_step;
    logic              w_core_ready;
    t_result           w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_frame  <= '0;
            r_cfg.frame_count  <= 9'd1;
            r_cfg.anim_mode    <= MODE_NORMAL;
            r_cfg.repeat_limit <= '0;
            r_cfg.frame_rate   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                CFG_START_FRAME:  r_cfg.start_frame  <= i_cfg_data[7:0];
                CFG_FRAME_COUNT:  r_cfg.frame_count  <= i_cfg_data[8:0];
                CFG_ANIM_MODE:    r_cfg.anim_mode    <= i_cfg_data[1:0];
                CFG_REPEAT_LIMIT: r_cfg.repeat_limit <= i_cfg_data[CNT_W-1:0];
                CFG_FRAME_RATE:   r_cfg.frame_rate   <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sfa_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_frame_rate  (r_cfg.frame_rate),
        .i_next_ready  (w_core_ready),
        .o_valid       (w_s1_valid),
        .o_action      (w_s1_action),
        .o_step        (w_s1_step)
    );

    sfa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_s1_valid),
        .i_action    (w_s1_action),
        .i_step      (w_s1_step),
        .o_ready     (w_core_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {{(16-IDX_W){1'b0}}, w_result.frame_index};
    assign m_axis_tuser = w_result.running;
    assign m_axis_tlast = w_result.end_reached;

endmodule

// ----- tb/sprite_frame_animator_tb.sv -----
module sprite_frame_animator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfa_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned MAX_PRINTED = 100;

    class anim_tracker;
        logic [7:0]       start_frame;
        logic [8:0]       frame_count;
        logic [1:0]       anim_mode;
        logic [CNT_W-1:0] repeat_limit;
        logic [9:0]       frame_rate;

        longint      pos;
        bit          backward;
        bit          running;
        int unsigned cycles;

        t_result     expected_frames[$];
        int unsigned errors;
        int unsigned frames_seen;

        function new();
            start_frame  = '0;
            frame_count  = 9'd1;
            anim_mode    = MODE_NORMAL;
            repeat_limit = '0;
            frame_rate   = '0;
            pos          = 0;
            backward     = 1'b0;
            running      = 1'b0;
            cycles       = 0;
            errors       = 0;
            frames_seen  = 0;
        endfunction

        function longint clamp_pos(longint v);
            if (v > longint'(POS_MAX)) begin
                return longint'(POS_MAX);
            end
            if (v < longint'(POS_MIN)) begin
                return longint'(POS_MIN);
            end
            return v;
        endfunction

        function longint frame_pos(longint f);
            return clamp_pos(f <<< FRAC_BITS);
        endfunction

        // integer part, truncated toward zero
        function longint pos_frame(longint p);
            if (p >= 0) begin
                return p >>> FRAC_BITS;
            end
            return -((-p) >>> FRAC_BITS);
        endfunction

        function int unsigned outstanding();
            return expected_frames.size();
        endfunction

        function void write_reg(t_cfg_addr addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_START_FRAME:  start_frame  = data[7:0];
                CFG_FRAME_COUNT:  frame_count  = data[8:0];
                CFG_ANIM_MODE:    anim_mode    = data[1:0];
                CFG_REPEAT_LIMIT: repeat_limit = data[CNT_W-1:0];
                CFG_FRAME_RATE:   frame_rate   = data[9:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic act, logic [DT_W-1:0] dt);
            longint  first_f;
            longint  last_f;
            longint  step_v;
            longint  fr;
            longint  freeze;
            bit      hit;
            t_result want;
            first_f = start_frame;
            last_f  = first_f + ((frame_count == 0) ? 1 : longint'(frame_count)) - 1;
            hit     = 1'b0;
            freeze  = 0;
            if (act == ACT_RESTART) begin
                pos      = frame_pos(first_f);
                backward = 1'b0;
                running  = 1'b1;
                cycles   = 0;
            end else if (running) begin
                step_v = longint'(frame_rate) * longint'(dt);
                if (FRAC_BITS >= 16) begin
                    step_v = step_v <<< (FRAC_BITS - 16);
                end else begin
                    step_v = step_v >>> (16 - FRAC_BITS);
                end
                if (anim_mode == MODE_REVERSED) begin
                    backward = 1'b1;
                end
                pos = clamp_pos(backward ? pos - step_v : pos + step_v);
                fr  = pos_frame(pos);
                case (anim_mode)
                    MODE_NORMAL: begin
                        if (fr > last_f) begin
                            pos    = frame_pos(first_f);
                            freeze = last_f;
                            hit    = 1'b1;
                        end
                    end
                    MODE_REVERSED: begin
                        if (fr < first_f) begin
                            pos    = frame_pos(last_f);
                            freeze = first_f;
                            hit    = 1'b1;
                        end
                    end
                    MODE_PINGPONG: begin
                        if (!backward && fr > last_f) begin
                            pos      = frame_pos(last_f);
                            backward = 1'b1;
                            freeze   = last_f;
                            hit      = 1'b1;
                        end else if (backward && fr < first_f) begin
                            pos      = frame_pos(first_f);
                            backward = 1'b0;
                            freeze   = first_f;
                            hit      = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (hit && repeat_limit != 0) begin
                    if (cycles < CNT_MAX) begin
                        cycles++;
                    end
                    if (cycles >= repeat_limit) begin
                        pos     = frame_pos(freeze);
                        running = 1'b0;
                    end
                end
            end
            want.frame_index = IDX_W'(pos_frame(pos));
            want.running     = running;
            want.end_reached = hit;
            expected_frames.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task check_frame(logic [IDX_W-1:0] idx, logic run, logic endr);
            t_result want;
            frames_seen++;
            if (expected_frames.size() == 0) begin
                report_mismatch($sformatf("frame %0d: unexpected, index %0d", frames_seen, idx));
                return;
            end
            want = expected_frames.pop_front();
            if (idx !== want.frame_index) begin
                report_mismatch($sformatf("frame %0d: frame_index %0d, want %0d",
                                          frames_seen, idx, want.frame_index));
            end
            if (run !== want.running) begin
                report_mismatch($sformatf("frame %0d: running %b, want %b",
                                          frames_seen, run, want.running));
            end
            if (endr !== want.end_reached) begin
                report_mismatch($sformatf("frame %0d: end_reached %b, want %b",
                                          frames_seen, endr, want.end_reached));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // delta_time
    logic                  s_axis_tuser;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;   // frame_index, zero pad
    logic                  m_axis_tuser;   // running
    logic                  m_axis_tlast;   // end_reached
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    anim_tracker tracker = new();
    bit          no_gaps = 1'b0;
    bit          hold_request = 1'b0;

    sprite_frame_animator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return DT_W'($urandom_range(0, 65535));
            default: return DT_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // output transactions
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_frame(m_axis_tdata[IDX_W-1:0], m_axis_tuser, m_axis_tlast);
        end
    end

    // receiver back-pressure
    initial begin
        int unsigned stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_tick(input logic act, input logic [DT_W-1:0] dt);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= dt;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_tick(act, dt);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_cfg(input t_cfg_addr addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(addr, data);
    endtask

    task automatic load_cfg(input logic [CFG_DATA_W-1:0] sf, input logic [CFG_DATA_W-1:0] fc,
                            input logic [CFG_DATA_W-1:0] md, input logic [CFG_DATA_W-1:0] lim,
                            input logic [CFG_DATA_W-1:0] rt);
        drain_results();
        write_cfg(CFG_START_FRAME, sf);
        write_cfg(CFG_FRAME_COUNT, fc);
        write_cfg(CFG_ANIM_MODE, md);
        write_cfg(CFG_REPEAT_LIMIT, lim);
        write_cfg(CFG_FRAME_RATE, rt);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned n_items, input bit pause_midway,
                             input bit hold_midway);
        logic [CFG_DATA_W-1:0] sf;
        logic [CFG_DATA_W-1:0] fc;
        logic [CFG_DATA_W-1:0] md;
        logic [CFG_DATA_W-1:0] lim;
        logic [CFG_DATA_W-1:0] rt;
        logic                  act;
        case ($urandom_range(0, 4))
            0:       sf = '0;
            1:       sf = 10'd255;
            2:       sf = CFG_DATA_W'($urandom_range(0, 1023));
            default: sf = CFG_DATA_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0:       fc = '0;
            1:       fc = 10'd1;
            2:       fc = 10'd256;
            3:       fc = 10'd511;
            4:       fc = CFG_DATA_W'($urandom_range(0, 1023));
            default: fc = CFG_DATA_W'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 7) == 0) begin
            md = CFG_DATA_W'($urandom_range(0, 1023));
        end else begin
            md = CFG_DATA_W'($urandom_range(MODE_NORMAL, MODE_PINGPONG));
        end
        case ($urandom_range(0, 5))
            0, 1:    lim = '0;
            2:       lim = 10'd1;
            3:       lim = 10'd255;
            4:       lim = CFG_DATA_W'($urandom_range(0, 1023));
            default: lim = CFG_DATA_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 5))
            0:       rt = '0;
            1:       rt = 10'd1023;
            2:       rt = CFG_DATA_W'($urandom_range(0, 1023));
            default: rt = CFG_DATA_W'($urandom_range(1, 120));
        endcase
        load_cfg(sf, fc, md, lim, rt);
        for (int unsigned i = 0; i < n_items; i++) begin
            if (pause_midway && i == n_items / 2) begin
                drain_results();
            end
            if (hold_midway && i == 5) begin
                hold_request = 1'b1;
            end
            // mostly well-formed runs: restart once stopped, rare stray restarts
            if ((i == 0 && $urandom_range(0, 3) != 0) ||
                (!tracker.running && $urandom_range(0, 3) != 0) ||
                $urandom_range(0, 24) == 0) begin
                act = ACT_RESTART;
            end else begin
                act = ACT_ADVANCE;
            end
            send_tick(act, pick_dt());
        end
    endtask

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_ADVANCE;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= CFG_START_FRAME;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // normal loop with a repeat limit of two, advance while stopped first
        load_cfg(10'd10, 10'd5, MODE_NORMAL, 10'd2, 10'd60);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_RESTART, 16'h0000);
        send_tick(ACT_ADVANCE, 16'h0000);
        send_tick(ACT_ADVANCE, 16'd4369);
        send_tick(ACT_ADVANCE, 16'd1092);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_RESTART, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);

        // reversed loop over 256 frames starting at frame 255
        load_cfg(10'd255, 10'd256, MODE_REVERSED, 10'd0, 10'd1023);
        send_tick(ACT_RESTART, 16'h5555);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'h8000);

        // pingpong with zero frame count
        load_cfg(10'd0, 10'd0, MODE_PINGPONG, 10'd255, 10'd1);
        send_tick(ACT_RESTART, 16'hAAAA);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);

        // bounce at the top, then normal mode with the direction left backward
        load_cfg(10'd0, 10'd4, MODE_PINGPONG, 10'd0, 10'd1023);
        send_tick(ACT_RESTART, 16'h0000);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        load_cfg(10'd0, 10'd4, MODE_NORMAL, 10'd0, 10'd1023);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);

        // unused mode runs up into saturation
        load_cfg(10'd200, 10'd511, MODE_UNUSED, 10'd0, 10'd1023);
        send_tick(ACT_RESTART, 16'h0000);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);
        send_tick(ACT_ADVANCE, 16'hFFFF);

        for (int unsigned ph = 0; ph < 16; ph++) begin
            no_gaps = (ph == 3 || ph == 6);
            run_phase($urandom_range(40, 60), ph % 4 == 1, ph == 6);
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sfa_pkg.sv
hdl/sfa_step.sv
hdl/sfa_core.sv
hdl/sprite_frame_animator.sv
tb/sprite_frame_animator_tb.sv
